// ----- rtl/ssvs_pkg.sv -----
// Shared constants, codes and types of the sorted sparse vector store.
package ssvs_pkg;

    localparam int CAPACITY   = 64;
    localparam int INDEX_BITS = 16;
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int SIZE_BITS  = INDEX_BITS + 1;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_SET  = 3'd0;
    localparam kind_t KIND_GET  = 3'd1;
    localparam kind_t KIND_ADD  = 3'd2;
    localparam kind_t KIND_SUB  = 3'd3;
    localparam kind_t KIND_READ = 3'd4;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_BAD_POS   = 2'd2;

    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } dp_cmd_t;

endpackage

// ----- rtl/ssvs_if.sv -----
// Channel interfaces: command items, result items and the size register write.
interface ssvs_req_if;
    logic                                    valid;
    logic                                    ready;
    ssvs_pkg::kind_t                         kind;
    logic [ssvs_pkg::INDEX_BITS-1:0]         index;
    logic signed [ssvs_pkg::VALUE_BITS-1:0]  value;
    logic [ssvs_pkg::POS_BITS-1:0]           position;
    modport source (output valid, kind, index, value, position, input ready);
    modport sink (input valid, kind, index, value, position, output ready);
endinterface

interface ssvs_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ssvs_pkg::VALUE_BITS-1:0]  value_out;
    logic [ssvs_pkg::INDEX_BITS-1:0]         index_out;
    logic                                    found;
    ssvs_pkg::status_t                       status;
    logic [ssvs_pkg::COUNT_BITS-1:0]         entry_count_out;
    logic [ssvs_pkg::SIZE_BITS-1:0]          logical_size;
    modport source (output valid, value_out, index_out, found, status, entry_count_out,
                    logical_size, input ready);
    modport sink (input valid, value_out, index_out, found, status, entry_count_out,
                  logical_size, output ready);
endinterface

interface ssvs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ssvs_pkg::SIZE_BITS-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/ssvs_dp.sv -----
// Datapath: sorted cell chain, counters, size register and result register.
module ssvs_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ssvs_pkg::dp_cmd_t                       cmd,
    input  ssvs_pkg::kind_t                         kind,
    input  logic [ssvs_pkg::INDEX_BITS-1:0]         index,
    input  logic signed [ssvs_pkg::VALUE_BITS-1:0]  value,
    input  logic [ssvs_pkg::POS_BITS-1:0]           position,
    input  logic                                    cfg_we,
    input  logic [ssvs_pkg::SIZE_BITS-1:0]          cfg_data,
    output logic signed [ssvs_pkg::VALUE_BITS-1:0]  value_out,
    output logic [ssvs_pkg::INDEX_BITS-1:0]         index_out,
    output logic                                    found,
    output ssvs_pkg::status_t                       status,
    output logic [ssvs_pkg::COUNT_BITS-1:0]         entry_count_out,
    output logic [ssvs_pkg::SIZE_BITS-1:0]          logical_size
);
    import ssvs_pkg::*;

    kind_t                   kind_reg;
    logic [INDEX_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic [POS_BITS-1:0]     pos_reg;

    logic [INDEX_BITS-1:0]   cell_idx_reg [CAPACITY];
    logic [VALUE_BITS-1:0]   cell_val_reg [CAPACITY];
    logic [COUNT_BITS-1:0]   count_reg;
    logic [SIZE_BITS-1:0]    grown_reg;
    logic [SIZE_BITS-1:0]    decl_reg;

    logic [CAPACITY-1:0]     lt_reg, lt_next;
    logic [CAPACITY-1:0]     eq_reg, eq_next;
    logic [VALUE_BITS-1:0]   hit_val_reg, hit_val_next;
    logic [INDEX_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic [VALUE_BITS-1:0]   rd_val_reg, rd_val_next;

    logic [VALUE_BITS-1:0]   vout_reg, vout_next;
    logic [INDEX_BITS-1:0]   iout_reg, iout_next;
    logic                    found_reg, found_next;
    status_t                 status_reg, status_next;
    logic [COUNT_BITS-1:0]   cnt_out_reg;
    logic [SIZE_BITS-1:0]    size_out_reg;

    logic                    hit, full, is_wr, do_ins, do_upd, grow;
    logic [VALUE_BITS-1:0]   new_val;
    logic [SIZE_BITS-1:0]    size_cur, key_ext, grown_next, size_next;
    logic [COUNT_BITS-1:0]   count_next;

    // Every cell compares itself against the key and the requested position at once.
    always_comb
    begin
        lt_next      = '0;
        eq_next      = '0;
        hit_val_next = '0;
        rd_idx_next  = '0;
        rd_val_next  = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (COUNT_BITS'(k) < count_reg)
            begin
                lt_next[k] = cell_idx_reg[k] < key_reg;
                eq_next[k] = cell_idx_reg[k] == key_reg;
            end
            if (eq_next[k])
                hit_val_next = hit_val_next | cell_val_reg[k];
            if (POS_BITS'(k) == pos_reg)
            begin
                rd_idx_next = cell_idx_reg[k];
                rd_val_next = cell_val_reg[k];
            end
        end
    end

    always_comb
    begin
        size_cur = (decl_reg > grown_reg) ? decl_reg : grown_reg;
        key_ext  = {1'b0, key_reg};
        hit      = |eq_reg;
        full     = count_reg == COUNT_BITS'(CAPACITY);
        is_wr    = (kind_reg == KIND_SET) || (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);
        do_upd   = is_wr && hit;
        do_ins   = is_wr && !hit && !full;

        unique case (kind_reg)
            KIND_ADD: new_val = hit ? hit_val_reg + val_reg : val_reg;
            KIND_SUB: new_val = hit ? hit_val_reg - val_reg : '0 - val_reg;
            default:  new_val = val_reg;
        endcase

        grow       = (kind_reg == KIND_SET) && (hit || !full) && (key_ext >= size_cur);
        grown_next = grow ? key_ext + SIZE_BITS'(1) : grown_reg;
        size_next  = (decl_reg > grown_next) ? decl_reg : grown_next;
        count_next = count_reg + COUNT_BITS'(do_ins);

        vout_next   = '0;
        iout_next   = '0;
        found_next  = 1'b0;
        status_next = STATUS_OK;
        if (is_wr)
        begin
            found_next = hit;
            if (hit || !full)
                vout_next = new_val;
            else
                status_next = STATUS_FULL;
        end
        else if (kind_reg == KIND_GET)
        begin
            found_next = hit;
            if (hit && key_ext < size_cur)
                vout_next = hit_val_reg;
        end
        else if (kind_reg == KIND_READ)
        begin
            if ({1'b0, pos_reg} < count_reg)
            begin
                found_next = 1'b1;
                vout_next  = rd_val_reg;
                iout_next  = rd_idx_reg;
            end
            else
                status_next = STATUS_BAD_POS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= index;
            val_reg  <= value;
            pos_reg  <= position;
        end
        if (cmd.eval)
        begin
            lt_reg      <= lt_next;
            eq_reg      <= eq_next;
            hit_val_reg <= hit_val_next;
            rd_idx_reg  <= rd_idx_next;
            rd_val_reg  <= rd_val_next;
        end
        if (cmd.commit)
        begin
            vout_reg     <= vout_next;
            iout_reg     <= iout_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            cnt_out_reg  <= count_next;
            size_out_reg <= size_next;
        end
    end

    // On insert, cells at or above the slot move up by one and the slot takes the new pair.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (cmd.commit)
            begin
                if (do_upd && eq_reg[k])
                    cell_val_reg[k] <= new_val;
                else if (do_ins && !lt_reg[k])
                begin
                    if (k == 0)
                    begin
                        cell_idx_reg[k] <= key_reg;
                        cell_val_reg[k] <= new_val;
                    end
                    else if (lt_reg[(k == 0) ? 0 : k - 1])
                    begin
                        cell_idx_reg[k] <= key_reg;
                        cell_val_reg[k] <= new_val;
                    end
                    else
                    begin
                        cell_idx_reg[k] <= cell_idx_reg[(k == 0) ? 0 : k - 1];
                        cell_val_reg[k] <= cell_val_reg[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            grown_reg <= '0;
            decl_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                decl_reg <= cfg_data;
            if (cmd.commit)
            begin
                count_reg <= count_next;
                grown_reg <= grown_next;
            end
        end
    end

    assign value_out       = vout_reg;
    assign index_out       = iout_reg;
    assign found           = found_reg;
    assign status          = status_reg;
    assign entry_count_out = cnt_out_reg;
    assign logical_size    = size_out_reg;

endmodule

// ----- rtl/ssvs_ctrl.sv -----
// Controller: sequences capture, compare and commit, and owns the command and result handshakes.
module ssvs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ssvs_pkg::dp_cmd_t  cmd
);
    import ssvs_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_COMMIT} state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready   = state_reg == ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_valid && in_ready;
    assign cmd.eval   = state_reg == ST_EVAL;
    // The result register must be free before a new item is committed.
    assign cmd.commit = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (cmd.load)
                        state_reg <= ST_EVAL;
                ST_EVAL:
                    state_reg <= ST_COMMIT;
                ST_COMMIT:
                    if (cmd.commit)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/sorted_sparse_vector_store.sv -----
// Top level of the sorted sparse vector store.
// Keeps up to 64 (index, value) pairs sorted by index in a chain of cells. Each command item
// passes through capture, a compare of the key against every cell at once, and a commit
// that updates or shifts the cells in one step and loads the result register. The next item
// is taken while a result still waits, but its commit waits until that result is taken.
// There is no clearing pass after reset; the size register write is always ready.
module sorted_sparse_vector_store (
    input logic        clk,
    input logic        rst_n,
    ssvs_req_if.sink   req,
    ssvs_rsp_if.source rsp,
    ssvs_cfg_if.sink   cfg
);
    import ssvs_pkg::*;

    dp_cmd_t cmd;

    assign cfg.ready = 1'b1;

    ssvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    ssvs_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (req.kind),
        .index           (req.index),
        .value           (req.value),
        .position        (req.position),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.data),
        .value_out       (rsp.value_out),
        .index_out       (rsp.index_out),
        .found           (rsp.found),
        .status          (rsp.status),
        .entry_count_out (rsp.entry_count_out),
        .logical_size    (rsp.logical_size)
    );

endmodule

// ----- test/ssvs_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench types: the record of one expected or observed result item.
package ssvs_tb_types;
    import ssvs_pkg::*;
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value_out;
        logic [INDEX_BITS-1:0]        index_out;
        logic                         found;
        status_t                      status;
        logic [COUNT_BITS-1:0]        entry_count_out;
        logic [SIZE_BITS-1:0]         logical_size;
    } store_result_t;
endpackage

// ----- test/sorted_sparse_vector_store_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the sorted sparse vector store with its own store model.
module sorted_sparse_vector_store_tb;
    import ssvs_pkg::*;
    import ssvs_tb_types::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    ssvs_req_if req ();
    ssvs_rsp_if rsp ();
    ssvs_cfg_if cfg ();

    sorted_sparse_vector_store u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // Model state of the store.
    logic [INDEX_BITS-1:0] model_keys [CAPACITY];
    logic [VALUE_BITS-1:0] model_vals [CAPACITY];
    int unsigned           model_count;
    logic [SIZE_BITS-1:0]  model_grown;
    logic [SIZE_BITS-1:0]  model_declared;

    store_result_t expected_results [$];
    int  error_count;
    int  result_count;
    int  cycle_count;
    bit  sender_busy_mode;
    bit  receiver_busy_mode;
    int  full_hits;
    int  bad_pos_hits;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [SIZE_BITS-1:0] model_size();
        return (model_declared > model_grown) ? model_declared : model_grown;
    endfunction

    // Computes one command's result and applies it to the model store.
    function automatic store_result_t predict_store(kind_t kind, logic [INDEX_BITS-1:0] key,
                                                    logic [VALUE_BITS-1:0] operand,
                                                    logic [POS_BITS-1:0] pos);
        store_result_t r;
        int unsigned slot;
        bit hit;
        logic [VALUE_BITS-1:0] nv;
        r = '0;
        slot = 0;
        while (slot < model_count && model_keys[slot] < key)
            slot++;
        hit = (slot < model_count) && (model_keys[slot] == key);
        if (kind == KIND_SET || kind == KIND_ADD || kind == KIND_SUB)
        begin
            r.found = hit;
            if (hit)
            begin
                if (kind == KIND_SET)
                    model_vals[slot] = operand;
                else if (kind == KIND_ADD)
                    model_vals[slot] = model_vals[slot] + operand;
                else
                    model_vals[slot] = model_vals[slot] - operand;
                r.value_out = model_vals[slot];
            end
            else if (model_count < CAPACITY)
            begin
                nv = (kind == KIND_SUB) ? -operand : operand;
                for (int k = model_count; k > slot; k--)
                begin
                    model_keys[k] = model_keys[k-1];
                    model_vals[k] = model_vals[k-1];
                end
                model_keys[slot] = key;
                model_vals[slot] = nv;
                model_count++;
                r.value_out = nv;
            end
            else
            begin
                r.status = STATUS_FULL;
                full_hits++;
            end
            if (kind == KIND_SET && r.status == STATUS_OK && {1'b0, key} >= model_size())
                model_grown = {1'b0, key} + 1'b1;
        end
        else if (kind == KIND_GET)
        begin
            r.found = hit;
            if (hit && {1'b0, key} < model_size())
                r.value_out = model_vals[slot];
        end
        else if (kind == KIND_READ)
        begin
            if (pos < model_count)
            begin
                r.value_out = model_vals[pos];
                r.index_out = model_keys[pos];
                r.found = 1'b1;
            end
            else
            begin
                r.status = STATUS_BAD_POS;
                bad_pos_hits++;
            end
        end
        r.entry_count_out = COUNT_BITS'(model_count);
        r.logical_size = model_size();
        return r;
    endfunction

    // Sends one command item, with random idle cycles before it in sender busy mode.
    // The item stays valid afterwards so that back-to-back items need no gap.
    task automatic send_command(kind_t kind, logic [INDEX_BITS-1:0] key,
                                logic [VALUE_BITS-1:0] operand, logic [POS_BITS-1:0] pos);
        while (sender_busy_mode && $urandom_range(99) < 36)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.kind     <= kind;
        req.index    <= key;
        req.value    <= operand;
        req.position <= pos;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_results.push_back(predict_store(kind, key, operand, pos));
        @(negedge clk);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_declared_size(logic [SIZE_BITS-1:0] size);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.data  <= size;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        model_declared = size;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Result checker: compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        store_result_t got;
        store_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.value_out, rsp.index_out, rsp.found, rsp.status,
                    rsp.entry_count_out, rsp.logical_size};
            result_count++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.value_out !== want.value_out)
                    $display("%0t: value_out expected %h actual %h", $time,
                             want.value_out, got.value_out);
                if (got.index_out !== want.index_out)
                    $display("%0t: index_out expected %h actual %h", $time,
                             want.index_out, got.index_out);
                if (got.found !== want.found)
                    $display("%0t: found expected %b actual %b", $time, want.found, got.found);
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.entry_count_out !== want.entry_count_out)
                    $display("%0t: entry_count_out expected %0d actual %0d", $time,
                             want.entry_count_out, got.entry_count_out);
                if (got.logical_size !== want.logical_size)
                    $display("%0t: logical_size expected %0d actual %0d", $time,
                             want.logical_size, got.logical_size);
                if (got !== want)
                    error_count++;
            end
        end
    end

    always @(negedge clk)
        rsp.ready <= !(receiver_busy_mode && $urandom_range(99) < 36);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_extremes();
        send_command(KIND_GET, 16'h0000, '0, '0);
        send_command(KIND_READ, '0, '0, 6'd0);
        send_command(KIND_SET, 16'hFFFF, 32'h7FFFFFFF, '0);
        send_command(KIND_SET, 16'h0000, 32'h80000000, '0);
        send_command(KIND_SET, 16'h0000, 32'h00000005, '0);
        send_command(KIND_ADD, 16'h0000, 32'h7FFFFFFF, '0);
        send_command(KIND_SUB, 16'h0000, 32'h80000000, '0);
        send_command(KIND_SUB, 16'h1234, 32'h00000001, '0);
        send_command(KIND_ADD, 16'h1234, 32'h00000001, '0);
        send_command(KIND_GET, 16'h1234, '0, '0);
        send_command(KIND_GET, 16'h4321, '0, '0);
        send_command(KIND_READ, '0, '0, 6'd1);
        send_command(KIND_READ, '0, '0, 6'd63);
        send_command(kind_t'(5), 16'hAAAA, 32'h55555555, 6'd2);
        send_command(kind_t'(7), 16'h5555, 32'hAAAAAAAA, 6'd21);
    endtask

    // Add beyond the size stores a pair that a get then hides.
    task automatic test_get_beyond_size();
        write_declared_size(17'd100);
        send_command(KIND_ADD, 16'd500, 32'd9, '0);
        send_command(KIND_GET, 16'd500, '0, '0);
        send_command(KIND_GET, 16'd99, '0, '0);
        write_declared_size(17'h10000);
        send_command(KIND_GET, 16'd500, '0, '0);
        write_declared_size(17'd0);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < CAPACITY + 4; k++)
            send_command(kind_t'($urandom_range(0, 1) ? KIND_SET : KIND_SUB),
                         16'($urandom_range(600, 65534)), $urandom, '0);
        send_command(KIND_ADD, 16'd3, 32'd1, '0);
        send_command(KIND_SET, 16'd599, 32'd1, '0);
        for (int k = 0; k < CAPACITY; k++)
            send_command(KIND_READ, '0, '0, POS_BITS'(k));
    endtask

    // Random commands, mostly over a narrow key range, so that hits and inserts both occur.
    task automatic test_random(int count);
        kind_t kind;
        logic [INDEX_BITS-1:0] key;
        for (int n = 0; n < count; n++)
        begin
            kind = kind_t'($urandom_range(0, 99) < 3 ? $urandom_range(5, 7)
                                                      : $urandom_range(0, 4));
            key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 90));
            if ($urandom_range(0, 9) == 0)
                key = model_keys[$urandom_range(0, model_count == 0 ? 0 : model_count - 1)];
            if (model_count == 0 && $urandom_range(0, 1))
                kind = KIND_SET;
            send_command(kind, key, $urandom, POS_BITS'($urandom));
        end
    endtask

    task automatic test_sizes();
        write_declared_size(17'h1FFFF & 17'h10000);
        test_random(250);
        write_declared_size(17'd40);
        test_random(250);
        write_declared_size(17'($urandom_range(0, 65536)));
        test_random(250);
    endtask

    initial
    begin
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        full_hits = 0;
        bad_pos_hits = 0;
        sender_busy_mode = 1'b1;
        receiver_busy_mode = 1'b1;
        model_count = 0;
        model_grown = '0;
        model_declared = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            model_keys[k] = '0;
            model_vals[k] = '0;
        end
        req.valid = 1'b0;
        req.kind = KIND_SET;
        req.index = '0;
        req.value = '0;
        req.position = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rsp.ready = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_get_beyond_size();
        test_random(375);
        sender_busy_mode = 1'b0;
        receiver_busy_mode = 1'b0;
        test_random(375);
        sender_busy_mode = 1'b1;
        receiver_busy_mode = 1'b1;
        test_full_table();
        test_sizes();
        drain_results();

        $display("Covered %0d results, %0d full-table inserts, %0d reads past the count.",
                 result_count, full_hits, bad_pos_hits);
        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
